/* rtl/csrc_pkg.sv */
package csrc_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int W_BITS         = (FRAC_BITS > 16) ? 16 : FRAC_BITS;
	localparam int MAX_OUT_PER_IN = 16;
	localparam int CNT_W          = (MAX_OUT_PER_IN > 1) ? $clog2(MAX_OUT_PER_IN) : 1;

	localparam int SAMPLE_W = 16;
	localparam int STEP_W   = 20;
	localparam int PHASE_W  = FRAC_BITS + 5;
	localparam int FILL_W   = 3;
	localparam int HIST_D   = 4;

	// datapath widths: coefficients, Horner accumulator, multiplier operands
	localparam int CO_W   = SAMPLE_W + 6;
	localparam int ACC_W  = W_BITS + 24;
	localparam int MA_W   = ACC_W - W_BITS;
	localparam int MB_W   = W_BITS + 1;
	localparam int PROD_W = MA_W + MB_W;

	localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
	localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(HIST_D);
	localparam logic [PHASE_W-1:0] ONE_PHASE  = PHASE_W'(1) << FRAC_BITS;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< W_BITS;
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(32768);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

/* rtl/cubic_sample_rate_converter_unit.sv */
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    left_sample, right_sample
// out       out  out_valid / out_stall  left_out, right_out, last_of_run
// cfg       in   cfg_valid / cfg_ready  phase_step
//
// an input beat that only fills history or is dropped goes from the check
// state back to idle; otherwise it makes n output beats (n up to 16)
// each output needs six steps per channel on the single 24x17 multiplier
// (Horner evaluation, upper and lower halves of the accumulator) plus one load
// reset clears history and phase, loads a step of 1.0; cfg_ready is always high
// a stalled output holds the sequencer before the next load, input is taken
// again as soon as the last output of a run sits in the output register
module cubic_sample_rate_converter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             left_sample,
	input  logic signed [15:0]             right_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             left_out,
	output logic signed [15:0]             right_out,
	output logic                           last_of_run,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csrc_pkg::STEP_W-1:0]    phase_step
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SK_MUL_A,
		SK_HI_1,
		SK_LO_1,
		SK_HI_2,
		SK_LO_2,
		SK_ROUND
	} step_t;

	state_t                              state_q;
	step_t                               step_q;
	logic                                ch_q;
	logic [csrc_pkg::CNT_W-1:0]          n_q;
	logic [csrc_pkg::FILL_W-1:0]         fill_q;
	logic [csrc_pkg::PHASE_W-1:0]        phase_q;
	logic [csrc_pkg::STEP_W-1:0]         step_reg_q;
	csrc_pkg::sample_t                   left_hist_q  [csrc_pkg::HIST_D];
	csrc_pkg::sample_t                   right_hist_q [csrc_pkg::HIST_D];
	logic signed [csrc_pkg::ACC_W-1:0]   acc_q;
	logic signed [csrc_pkg::ACC_W-1:0]   part_q;
	csrc_pkg::sample_t                   left_res_q;
	csrc_pkg::sample_t                   right_res_q;
	logic                                out_valid_q;
	csrc_pkg::sample_t                   left_out_q;
	csrc_pkg::sample_t                   right_out_q;
	logic                                last_q;

	logic signed [csrc_pkg::CO_W-1:0]    e0, e1, e2, e3;
	logic signed [csrc_pkg::CO_W-1:0]    coef_a, coef_b, coef_c, coef_d;
	logic signed [csrc_pkg::MA_W-1:0]    ma;
	logic signed [csrc_pkg::MB_W-1:0]    mb;
	logic signed [csrc_pkg::PROD_W-1:0]  prod;
	logic signed [csrc_pkg::ACC_W-1:0]   rnd;
	logic signed [csrc_pkg::ACC_W-1:0]   shr;
	csrc_pkg::sample_t                   sat;
	logic [csrc_pkg::PHASE_W-1:0]        phase_sum;
	logic                                run_last;
	logic [csrc_pkg::PHASE_W-1:0]        phase_end;
	logic                                in_take;
	logic                                out_free;

	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid   = out_valid_q;
	assign left_out    = left_out_q;
	assign right_out   = right_out_q;
	assign last_of_run = last_q;

	// history of the channel being worked on
	always_comb begin
		if (ch_q) begin
			e0 = csrc_pkg::CO_W'(right_hist_q[0]);
			e1 = csrc_pkg::CO_W'(right_hist_q[1]);
			e2 = csrc_pkg::CO_W'(right_hist_q[2]);
			e3 = csrc_pkg::CO_W'(right_hist_q[3]);
		end else begin
			e0 = csrc_pkg::CO_W'(left_hist_q[0]);
			e1 = csrc_pkg::CO_W'(left_hist_q[1]);
			e2 = csrc_pkg::CO_W'(left_hist_q[2]);
			e3 = csrc_pkg::CO_W'(left_hist_q[3]);
		end
	end

	// twice the catmull-rom coefficients
	assign coef_a = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
	assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign coef_c = e2 - e0;
	assign coef_d = e1 <<< 1;

	always_comb begin
		case (step_q)
			SK_MUL_A: ma = csrc_pkg::MA_W'(coef_a);
			SK_HI_1,
			SK_HI_2:  ma = acc_q[csrc_pkg::ACC_W-1:csrc_pkg::W_BITS];
			SK_LO_1,
			SK_LO_2:  ma = signed'(csrc_pkg::MA_W'({1'b0, acc_q[csrc_pkg::W_BITS-1:0]}));
			default:  ma = '0;
		endcase
	end

	assign mb   = signed'({1'b0, phase_q[csrc_pkg::FRAC_BITS-1 -: csrc_pkg::W_BITS]});
	assign prod = csrc_pkg::PROD_W'(ma) * csrc_pkg::PROD_W'(mb);

	// round half up at the extra bit of the doubled coefficients, then clip
	assign rnd = acc_q + csrc_pkg::ROUND_BIAS;
	assign shr = rnd >>> (csrc_pkg::W_BITS + 1);
	always_comb begin
		if (shr > csrc_pkg::SAT_HI) begin
			sat = csrc_pkg::SAMPLE_W'(csrc_pkg::SAT_HI);
		end else if (shr < csrc_pkg::SAT_LO) begin
			sat = csrc_pkg::SAMPLE_W'(csrc_pkg::SAT_LO);
		end else begin
			sat = csrc_pkg::SAMPLE_W'(shr);
		end
	end

	assign phase_sum = phase_q + csrc_pkg::PHASE_W'(step_reg_q);
	assign run_last  = (n_q == csrc_pkg::CNT_W'(csrc_pkg::MAX_OUT_PER_IN - 1)) ||
		(phase_sum >= csrc_pkg::ONE_PHASE);
	assign phase_end = (phase_sum >= csrc_pkg::ONE_PHASE) ?
		(phase_sum - csrc_pkg::ONE_PHASE) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= SK_MUL_A;
			ch_q        <= 1'b0;
			n_q         <= '0;
			fill_q      <= '0;
			phase_q     <= '0;
			step_reg_q  <= csrc_pkg::STEP_RESET;
			for (int i = 0; i < csrc_pkg::HIST_D; i++) begin
				left_hist_q[i]  <= '0;
				right_hist_q[i] <= '0;
			end
			acc_q       <= '0;
			part_q      <= '0;
			left_res_q  <= '0;
			right_res_q <= '0;
			out_valid_q <= 1'b0;
			left_out_q  <= '0;
			right_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				step_reg_q <= phase_step;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						for (int i = 0; i < csrc_pkg::HIST_D - 1; i++) begin
							left_hist_q[i]  <= left_hist_q[i+1];
							right_hist_q[i] <= right_hist_q[i+1];
						end
						left_hist_q[csrc_pkg::HIST_D-1]  <= left_sample;
						right_hist_q[csrc_pkg::HIST_D-1] <= right_sample;
						if (fill_q != csrc_pkg::FILL_FULL) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (fill_q != csrc_pkg::FILL_FULL) begin
						state_q <= ST_IDLE;
					end else if (phase_q >= csrc_pkg::ONE_PHASE) begin
						// decimating: this beat makes no output
						phase_q <= phase_q - csrc_pkg::ONE_PHASE;
						state_q <= ST_IDLE;
					end else begin
						n_q     <= '0;
						ch_q    <= 1'b0;
						step_q  <= SK_MUL_A;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					case (step_q)
						SK_MUL_A: begin
							acc_q  <= csrc_pkg::ACC_W'(prod) +
								(csrc_pkg::ACC_W'(coef_b) <<< csrc_pkg::W_BITS);
							step_q <= SK_HI_1;
						end
						SK_HI_1: begin
							part_q <= csrc_pkg::ACC_W'(prod);
							step_q <= SK_LO_1;
						end
						SK_LO_1: begin
							acc_q  <= part_q + csrc_pkg::ACC_W'(prod >>> csrc_pkg::W_BITS) +
								(csrc_pkg::ACC_W'(coef_c) <<< csrc_pkg::W_BITS);
							step_q <= SK_HI_2;
						end
						SK_HI_2: begin
							part_q <= csrc_pkg::ACC_W'(prod);
							step_q <= SK_LO_2;
						end
						SK_LO_2: begin
							acc_q  <= part_q + csrc_pkg::ACC_W'(prod >>> csrc_pkg::W_BITS) +
								(csrc_pkg::ACC_W'(coef_d) <<< csrc_pkg::W_BITS);
							step_q <= SK_ROUND;
						end
						SK_ROUND: begin
							step_q <= SK_MUL_A;
							if (ch_q) begin
								right_res_q <= sat;
								state_q     <= ST_EMIT;
							end else begin
								left_res_q <= sat;
								ch_q       <= 1'b1;
							end
						end
						default: begin
							step_q <= SK_MUL_A;
						end
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						left_out_q  <= left_res_q;
						right_out_q <= right_res_q;
						last_q      <= run_last;
						ch_q        <= 1'b0;
						if (run_last) begin
							phase_q <= phase_end;
							state_q <= ST_IDLE;
						end else begin
							phase_q <= phase_sum;
							n_q     <= n_q + 1'b1;
							state_q <= ST_CALC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
